### hdl/vfvp_pkg.sv
// Shared types, constants and lookup functions for the voxel face vertex packer.
package vfvp_pkg;

    localparam int COORD_BITS = 9;
    localparam int SUB_BITS = COORD_BITS - 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int STEP_BITS = 4;
    localparam int VERTEX_STEPS = 4;
    localparam int TOTAL_STEPS = 10;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX = 1'b1;

    localparam logic [2:0] FACE_TOP = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic [3:0] BRIGHT_TOP = 4'd15;
    localparam logic [3:0] BRIGHT_BOTTOM = 4'd7;
    localparam logic [3:0] BRIGHT_NORTH = 4'd12;
    localparam logic [3:0] BRIGHT_SIDE = 4'd11;

    localparam logic [1:0] NORTH_FACE_RESET = 2'd2;

    typedef struct packed {
        logic [4:0]  pos_x;
        logic [4:0]  pos_y;
        logic [4:0]  pos_z;
        logic [2:0]  face;
        logic [11:0] tex_layer;
        logic [7:0]  occluders;
        logic [3:0]  bright;
        logic [15:0] base;
    } face_req_t;

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
    } corner_mask_t;

    typedef struct packed {
        logic push;
    } queue_wr_t;

    typedef struct packed {
        logic pop;
    } queue_rd_t;

    // Bit i of each mask is the unit offset of corner i along that axis.
    function automatic corner_mask_t face_offsets(input logic [2:0] face);
        corner_mask_t m;
        case (face)
            3'd0: m = '{x: 4'b1001, y: 4'b1100, z: 4'b1111};
            3'd1: m = '{x: 4'b1111, y: 4'b1100, z: 4'b0110};
            3'd2: m = '{x: 4'b0110, y: 4'b1100, z: 4'b0000};
            3'd3: m = '{x: 4'b0000, y: 4'b1100, z: 4'b1001};
            3'd4: m = '{x: 4'b0110, y: 4'b1111, z: 4'b1100};
            3'd5: m = '{x: 4'b1001, y: 4'b0000, z: 4'b1100};
            default: m = '{x: 4'b0000, y: 4'b0000, z: 4'b0000};
        endcase
        return m;
    endfunction

    function automatic logic [1:0] tri_offset(input logic [2:0] t);
        logic [1:0] r;
        case (t)
            3'd0: r = 2'd0;
            3'd1: r = 2'd1;
            3'd2: r = 2'd3;
            3'd3: r = 2'd1;
            3'd4: r = 2'd2;
            3'd5: r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/voxel_face_vertex_packer.sv
// Top level of the voxel face vertex packer: front end, request queue and back end.
//
// Each append request for a visible face (0 to 5) produces ten results: four vertex
// word pairs followed by six triangle indices, the sixth marked by m_tlast. Results
// leave at one per cycle while m_tready holds and a face is queued, from the back end's
// single output register and step counter. The front end accepts a new request every
// cycle while the two-entry queue has room, so start requests and faces numbered six
// or seven, which produce no results, are accepted at that rate as well.
module voxel_face_vertex_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[4:0], pos_y[9:5], pos_z[14:10], face[17:15], tex_layer[29:18],
    // occluders[37:30], zero padding[39:38]
    input  logic [39:0] s_tdata,
    // opcode[0]
    input  logic [0:0]  s_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // word_low[31:0], word_high[63:32]
    output logic [63:0] m_tdata,
    // kind[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    vfvp_pkg::queue_wr_t wr_ctl;
    vfvp_pkg::queue_rd_t rd_ctl;
    vfvp_pkg::face_req_t wr_data;
    vfvp_pkg::face_req_t rd_data;
    logic                queue_full;
    logic                rd_valid;

    vfvp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .wr_ctl     (wr_ctl),
        .queue_full (queue_full),
        .wr_data    (wr_data)
    );

    vfvp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_ctl   (wr_ctl),
        .wr_data  (wr_data),
        .full     (queue_full),
        .rd_ctl   (rd_ctl),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    vfvp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .rd_ctl   (rd_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_last_is_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[0] == vfvp_pkg::KIND_INDEX))
        else $error("Last marker on a vertex result.");

    a_index_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == vfvp_pkg::KIND_INDEX)) |-> (m_tdata[63:32] == '0))
        else $error("Index result with a nonzero high word.");

    a_vertex_ao_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == vfvp_pkg::KIND_VERTEX)) |-> (m_tdata[63:61] >= 3'd3))
        else $error("Vertex occlusion level below the minimum.");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ctl.pop |-> rd_valid)
        else $error("Queue popped while empty.");

endmodule

### hdl/vfvp_front.sv
// Front end: accepts requests, classifies them and queues valid faces with their index base.
module vfvp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    output vfvp_pkg::queue_wr_t wr_ctl,
    input  logic                queue_full,
    output vfvp_pkg::face_req_t wr_data
);

    logic [15:0] count_reg, count_next;
    logic [1:0]  north_reg;
    logic        accept;
    logic        is_start;
    logic        is_face;
    logic [2:0]  face;
    logic [3:0]  bright;

    assign s_tready = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept = s_tvalid && s_tready;
    assign face = s_tdata[17:15];
    assign is_start = (s_tuser[0] == vfvp_pkg::OP_START);
    assign is_face = !is_start && (face <= vfvp_pkg::FACE_BOTTOM);

    always_comb begin
        if (face == vfvp_pkg::FACE_TOP) begin
            bright = vfvp_pkg::BRIGHT_TOP;
        end else if (face == vfvp_pkg::FACE_BOTTOM) begin
            bright = vfvp_pkg::BRIGHT_BOTTOM;
        end else if (face == {1'b0, north_reg}) begin
            bright = vfvp_pkg::BRIGHT_NORTH;
        end else begin
            bright = vfvp_pkg::BRIGHT_SIDE;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept && is_start) begin
            count_next = '0;
        end else if (accept && is_face) begin
            count_next = count_reg + 16'd4;
        end
    end

    assign wr_ctl.push = accept && is_face;
    assign wr_data.pos_x = s_tdata[4:0];
    assign wr_data.pos_y = s_tdata[9:5];
    assign wr_data.pos_z = s_tdata[14:10];
    assign wr_data.face = face;
    assign wr_data.tex_layer = s_tdata[29:18];
    assign wr_data.occluders = s_tdata[37:30];
    assign wr_data.bright = bright;
    assign wr_data.base = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            north_reg <= vfvp_pkg::NORTH_FACE_RESET;
        end else begin
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                north_reg <= cfg_data;
            end
        end
    end

endmodule

### hdl/vfvp_queue.sv
// Short queue of face requests between the front and back ends.
module vfvp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  vfvp_pkg::queue_wr_t wr_ctl,
    input  vfvp_pkg::face_req_t wr_data,
    output logic                full,
    input  vfvp_pkg::queue_rd_t rd_ctl,
    output logic                rd_valid,
    output vfvp_pkg::face_req_t rd_data
);

    localparam int CNT_BITS = $clog2(vfvp_pkg::QUEUE_DEPTH + 1);

    vfvp_pkg::face_req_t mem [vfvp_pkg::QUEUE_DEPTH];
    logic [vfvp_pkg::QPTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign full = (cnt_reg == CNT_BITS'(vfvp_pkg::QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = mem[rptr_reg];
    assign do_push = wr_ctl.push && !full;
    assign do_pop = rd_ctl.pop && rd_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

endmodule

### hdl/vfvp_back.sv
// Back end: steps through four vertex results and six index results for each queued face.
module vfvp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_valid,
    input  vfvp_pkg::face_req_t rd_data,
    output vfvp_pkg::queue_rd_t rd_ctl,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    localparam int CB = vfvp_pkg::COORD_BITS;
    localparam int SB = vfvp_pkg::SUB_BITS;

    logic [vfvp_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [31:0] m_lo_reg;
    logic [31:0] m_hi_reg;
    logic        m_last_reg;

    logic        advance;
    logic        final_step;
    logic        is_vertex;
    logic [1:0]  corner;
    logic [1:0]  corner_nx;
    logic [2:0]  tri_step;
    vfvp_pkg::corner_mask_t offs;
    logic [SB-1:0] sx, sy, sz;
    logic [CB-1:0] cx, cy, cz;
    logic [4:0]  u_val, v_val;
    logic        occ_a, occ_b, occ_c;
    logic [2:0]  ao;
    logic [63:0] lo_wide;
    logic [31:0] vert_lo, vert_hi;
    logic [15:0] idx;
    logic        kind_d;
    logic [31:0] lo_d, hi_d;
    logic        last_d;

    assign advance = rd_valid && (!m_valid_reg || m_tready);
    assign final_step = (step_reg == vfvp_pkg::STEP_BITS'(vfvp_pkg::TOTAL_STEPS - 1));
    assign is_vertex = (step_reg < vfvp_pkg::STEP_BITS'(vfvp_pkg::VERTEX_STEPS));
    assign corner = step_reg[1:0];
    assign corner_nx = corner + 2'd1;
    assign tri_step = 3'(step_reg - vfvp_pkg::STEP_BITS'(vfvp_pkg::VERTEX_STEPS));

    assign offs = vfvp_pkg::face_offsets(rd_data.face);
    assign sx = SB'(rd_data.pos_x) + SB'(offs.x[corner]);
    assign sy = SB'(rd_data.pos_y) + SB'(offs.y[corner]);
    assign sz = SB'(rd_data.pos_z) + SB'(offs.z[corner]);
    assign cx = {sx, 4'b0000};
    assign cy = {sy, 4'b0000};
    assign cz = {sz, 4'b0000};
    assign u_val = (corner[0] ^ corner[1]) ? 5'd16 : 5'd0;
    assign v_val = !corner[1] ? 5'd16 : 5'd0;

    assign occ_a = rd_data.occluders[{corner, 1'b0}];
    assign occ_b = rd_data.occluders[{corner, 1'b1}];
    assign occ_c = rd_data.occluders[{corner_nx, 1'b0}];
    assign ao = (occ_a && occ_c) ? 3'd3
              : 3'd7 - 3'(occ_a) - 3'(occ_b) - 3'(occ_c);

    assign lo_wide = 64'(cx) | (64'(cy) << CB) | (64'(cz) << (2 * CB))
                   | (64'(u_val) << (3 * CB));
    assign vert_lo = lo_wide[31:0];
    assign vert_hi = {ao, rd_data.bright, rd_data.bright, rd_data.bright,
                      rd_data.tex_layer, v_val};
    assign idx = rd_data.base + 16'(vfvp_pkg::tri_offset(tri_step));

    always_comb begin
        if (is_vertex) begin
            kind_d = vfvp_pkg::KIND_VERTEX;
            lo_d = vert_lo;
            hi_d = vert_hi;
            last_d = 1'b0;
        end else begin
            kind_d = vfvp_pkg::KIND_INDEX;
            lo_d = 32'(idx);
            hi_d = '0;
            last_d = final_step;
        end
    end

    always_comb begin
        step_next = step_reg;
        if (advance) begin
            step_next = final_step ? '0 : step_reg + 1'b1;
        end
    end

    assign rd_ctl.pop = advance && final_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_kind_reg <= kind_d;
            m_lo_reg <= lo_d;
            m_hi_reg <= hi_d;
            m_last_reg <= last_d;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {m_hi_reg, m_lo_reg};
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

endmodule
